// File: design/dpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

    localparam int FOCAL_W  = 28;
    localparam int UNITS_W  = 16;
    localparam int Z_W      = 23;
    localparam int STEP_W   = 7;
    localparam int RAW_W    = 32;
    localparam int PT_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int Q_DEPTH  = 4;
    // quotient bits of the projection divide; anything above saturates
    localparam int PQUO_W   = 33;

    localparam logic [FOCAL_W-1:0] RST_FOCAL_X  = 28'd28636922;
    localparam logic [FOCAL_W-1:0] RST_FOCAL_Y  = 28'd28636922;
    localparam logic [FOCAL_W-1:0] RST_CENTER_X = 28'd28306346;
    localparam logic [FOCAL_W-1:0] RST_CENTER_Y = 28'd15737409;
    localparam logic [UNITS_W-1:0] RST_UNITS    = 16'd1000;
    localparam logic [Z_W-1:0]     RST_LOWER    = 23'd32768;
    localparam logic [Z_W-1:0]     RST_UPPER    = 23'd327680;
    localparam logic [STEP_W-1:0]  RST_STEP     = 7'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_UNITS    = 3'd4,
        CFG_LOWER    = 3'd5,
        CFG_UPPER    = 3'd6,
        CFG_STEP     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic [FOCAL_W-1:0] center_x;
        logic [FOCAL_W-1:0] center_y;
        logic [UNITS_W-1:0] units;
        logic [Z_W-1:0]     depth_lower;
        logic [Z_W-1:0]     depth_upper;
        logic [STEP_W-1:0]  pixel_step;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/depth_pixel_backprojection_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: column, row, raw_depth; tuser: is_float
// m_axis    out  tvalid/tready          tdata: point_x, point_y, point_z; tuser: point_valid
// cfg       in   wen (no wait)          idx, wdata
//
// One pixel per clock sustained unless the output stalls. Front end: input
// register, 23-stage divider for depth and step tests, output register. Back end:
// offset, scale and sign registers, 33-stage projection divider, output register.
// Reset is synchronous and needs no clearing pass. A stalled output holds the back
// end only; the 4-entry queue lets the front end keep taking pixels until it fills.
module depth_pixel_backprojection_top #(
    parameter int COORD_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // column, row, raw_depth, zero pad
    input  wire logic [((2*COORD_BITS+39)/8)*8-1:0] i_s_axis_tdata,
    // is_float
    input  wire logic [0:0] i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  wire logic   i_m_axis_tready,
    // point_x, point_y, point_z, zero pad
    output logic [87:0] o_m_axis_tdata,
    // point_valid
    output logic [0:0]  o_m_axis_tuser,

    input  wire logic                              i_cfg_wen,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int ZW   = dpb_pkg::Z_W;
    localparam int PTW  = dpb_pkg::PT_W;
    localparam int Q_W  = 1 + 2*COORD_BITS + ZW;

    dpb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x     <= dpb_pkg::RST_FOCAL_X;
            r_cfg.focal_y     <= dpb_pkg::RST_FOCAL_Y;
            r_cfg.center_x    <= dpb_pkg::RST_CENTER_X;
            r_cfg.center_y    <= dpb_pkg::RST_CENTER_Y;
            r_cfg.units       <= dpb_pkg::RST_UNITS;
            r_cfg.depth_lower <= dpb_pkg::RST_LOWER;
            r_cfg.depth_upper <= dpb_pkg::RST_UPPER;
            r_cfg.pixel_step  <= dpb_pkg::RST_STEP;
        end else if (i_cfg_wen) begin
            case (dpb_pkg::t_cfg_idx'(i_cfg_idx))
                dpb_pkg::CFG_FOCAL_X:  r_cfg.focal_x     <= i_cfg_wdata;
                dpb_pkg::CFG_FOCAL_Y:  r_cfg.focal_y     <= i_cfg_wdata;
                dpb_pkg::CFG_CENTER_X: r_cfg.center_x    <= i_cfg_wdata;
                dpb_pkg::CFG_CENTER_Y: r_cfg.center_y    <= i_cfg_wdata;
                dpb_pkg::CFG_UNITS:    r_cfg.units       <= i_cfg_wdata[dpb_pkg::UNITS_W-1:0];
                dpb_pkg::CFG_LOWER:    r_cfg.depth_lower <= i_cfg_wdata[ZW-1:0];
                dpb_pkg::CFG_UPPER:    r_cfg.depth_upper <= i_cfg_wdata[ZW-1:0];
                dpb_pkg::CFG_STEP:     r_cfg.pixel_step  <= i_cfg_wdata[dpb_pkg::STEP_W-1:0];
                default:               r_cfg             <= r_cfg;
            endcase
        end
    end

    logic                  f_push, f_ok, q_full, q_empty, q_pop;
    logic [COORD_BITS-1:0] f_col, f_row;
    logic [ZW-1:0]         f_z;
    logic [Q_W-1:0]        q_data;

    dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_col      (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_row      (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_is_float (i_s_axis_tuser[0]),
        .i_raw      (i_s_axis_tdata[2*COORD_BITS+31:2*COORD_BITS]),
        .i_full     (q_full),
        .o_push     (f_push),
        .o_ok       (f_ok),
        .o_col      (f_col),
        .o_row      (f_row),
        .o_z        (f_z)
    );

    dpb_fifo #(.W(Q_W), .DEPTH(dpb_pkg::Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ok, f_z, f_row, f_col}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    logic           b_pv;
    logic [PTW-1:0] b_x, b_y;
    logic [ZW-1:0]  b_z;

    dpb_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .i_ok          (q_data[Q_W-1]),
        .i_col         (q_data[COORD_BITS-1:0]),
        .i_row         (q_data[2*COORD_BITS-1:COORD_BITS]),
        .i_z           (q_data[Q_W-2:2*COORD_BITS]),
        .i_ready       (i_m_axis_tready),
        .o_valid       (o_m_axis_tvalid),
        .o_point_valid (b_pv),
        .o_x           (b_x),
        .o_y           (b_y),
        .o_z           (b_z)
    );

    assign o_m_axis_tdata = {1'b0, b_z, b_y, b_x};
    assign o_m_axis_tuser = b_pv;

endmodule

`default_nettype wire

// File: design/dpb_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The bits of i_num above QUO_W must be below i_den for a correct quotient.
module dpb_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 23,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic      [QUO_W-1:0]  o_quo,
    output logic      [DEN_W-1:0]  o_rem,
    output logic      [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_low  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    logic [DEN_W-1:0] rem_init;

    generate
        if (NUM_W > QUO_W) begin : g_hi
            assign rem_init = DEN_W'(i_num[NUM_W-1:QUO_W]);
        end else begin : g_nohi
            assign rem_init = '0;
        end
    endgenerate

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++) begin : g_stage
            logic [DEN_W-1:0]  rem_in;
            logic [QUO_W-1:0]  low_in;
            logic [QUO_W-1:0]  quo_in;
            logic [DEN_W-1:0]  den_in;
            logic [SIDE_W-1:0] side_in;
            logic [DEN_W:0]    trial;
            logic              ge;

            if (s == 0) begin : g_first
                assign rem_in  = rem_init;
                assign low_in  = i_num[QUO_W-1:0];
                assign quo_in  = '0;
                assign den_in  = i_den;
                assign side_in = i_side;
            end else begin : g_next
                assign rem_in  = r_rem[s-1];
                assign low_in  = r_low[s-1];
                assign quo_in  = r_quo[s-1];
                assign den_in  = r_den[s-1];
                assign side_in = r_side[s-1];
            end

            assign trial = {rem_in, low_in[QUO_W-1]};
            assign ge    = trial >= {1'b0, den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                    r_low[s]  <= {low_in[QUO_W-2:0], 1'b0};
                    r_quo[s]  <= {quo_in[QUO_W-2:0], ge};
                    r_den[s]  <= den_in;
                    r_side[s] <= side_in;
                end
            end
        end
    endgenerate

    assign o_quo  = r_quo[QUO_W-1];
    assign o_rem  = r_rem[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

`default_nettype wire

// File: design/dpb_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front end: decode the depth word, test the grid step and the depth range,
// and produce the Q7.16 depth of each pixel.
module dpb_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dpb_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [COORD_BITS-1:0]      i_col,
    input  wire logic [COORD_BITS-1:0]      i_row,
    input  wire logic                       i_is_float,
    input  wire logic [dpb_pkg::RAW_W-1:0]  i_raw,
    input  wire logic                       i_full,
    output logic                            o_push,
    output logic                            o_ok,
    output logic [COORD_BITS-1:0]           o_col,
    output logic [COORD_BITS-1:0]           o_row,
    output logic [dpb_pkg::Z_W-1:0]         o_z
);

    localparam int ZW    = dpb_pkg::Z_W;
    localparam int UW    = dpb_pkg::UNITS_W;
    localparam int SW    = dpb_pkg::STEP_W;
    localparam int V     = ZW + 2;
    localparam int BND_W = ZW + UW;
    localparam int CSIDE_W = 1 + 1 + ZW + 1 + UW;

    logic [V-1:0] r_vld;
    logic         f_en;

    assign f_en    = !r_vld[V-1] || !i_full;
    assign o_ready = f_en;
    assign o_push  = r_vld[V-1] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (f_en) begin
            r_vld <= {r_vld[V-2:0], i_valid};
        end
    end

    // float decode
    logic [7:0]  ex;
    logic [7:0]  ex_eff;
    logic [23:0] mant;
    logic [7:0]  rsh;
    logic [4:0]  rsh_c;
    logic [24:0] smask;
    logic [23:0] fl_full;
    logic        fpre;
    logic        sticky;

    always_comb begin
        ex      = i_raw[30:23];
        ex_eff  = (ex == 8'd0) ? 8'd1 : ex;
        mant    = {(ex != 8'd0), i_raw[22:0]};
        // a float at or above 2^7 meters always lands above the upper bound
        fpre    = (ex != 8'hFF) && !i_raw[31] && (i_raw[30:0] != 31'd0) && (ex_eff < 8'd134);
        rsh     = 8'd134 - ex_eff;
        rsh_c   = (rsh > 8'd24) ? 5'd24 : rsh[4:0];
        fl_full = mant >> rsh_c;
        smask   = (25'd1 << rsh_c) - 25'd1;
        sticky  = |(mant & smask[23:0]);
    end

    logic [SW-1:0]         step_eff;
    logic [UW-1:0]         units_eff;
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [SW-1:0]         r_step;
    logic                  r_is_float, r_fpre, r_sticky;
    logic [ZW-1:0]         r_fl;
    logic [UW-1:0]         r_cnt, r_units;
    logic [BND_W-1:0]      r_lo_prod, r_hi_prod;

    assign step_eff  = (i_cfg.pixel_step == '0) ? SW'(1) : i_cfg.pixel_step;
    assign units_eff = (i_cfg.units == '0) ? UW'(1) : i_cfg.units;

    // bounds scaled by units; settled long before any item reaches the compare
    always_ff @(posedge i_clk) begin
        r_lo_prod <= BND_W'(i_cfg.depth_lower) * BND_W'(units_eff);
        r_hi_prod <= BND_W'(i_cfg.depth_upper) * BND_W'(units_eff);
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_col      <= i_col;
            r_row      <= i_row;
            r_step     <= step_eff;
            r_is_float <= i_is_float;
            r_fpre     <= fpre;
            r_fl       <= fl_full[ZW-1:0];
            r_sticky   <= sticky;
            r_cnt      <= i_raw[UW-1:0];
            r_units    <= units_eff;
        end
    end

    logic [SW-1:0]         col_rem, row_rem;
    logic [COORD_BITS-1:0] d_col, d_row;
    logic [ZW-1:0]         cnt_quo;
    logic [CSIDE_W-1:0]    d_side;

    dpb_div #(.NUM_W(ZW), .DEN_W(SW), .QUO_W(ZW), .SIDE_W(COORD_BITS)) u_col_div (
        .i_clk (i_clk), .i_en (f_en),
        .i_num (ZW'(r_col)), .i_den (r_step), .i_side (r_col),
        .o_quo (), .o_rem (col_rem), .o_side (d_col)
    );

    dpb_div #(.NUM_W(ZW), .DEN_W(SW), .QUO_W(ZW), .SIDE_W(COORD_BITS)) u_row_div (
        .i_clk (i_clk), .i_en (f_en),
        .i_num (ZW'(r_row)), .i_den (r_step), .i_side (r_row),
        .o_quo (), .o_rem (row_rem), .o_side (d_row)
    );

    dpb_div #(.NUM_W(2*UW), .DEN_W(UW), .QUO_W(ZW), .SIDE_W(CSIDE_W)) u_cnt_div (
        .i_clk (i_clk), .i_en (f_en),
        .i_num ({r_cnt, {UW{1'b0}}}), .i_den (r_units),
        .i_side ({r_is_float, r_fpre, r_fl, r_sticky, r_cnt}),
        .o_quo (cnt_quo), .o_rem (), .o_side (d_side)
    );

    logic          s_is_float, s_fpre, s_sticky;
    logic [ZW-1:0] s_fl;
    logic [UW-1:0] s_cnt;
    logic [BND_W-1:0] s_num;
    logic          step_ok, cnt_ok, flt_ok, ok;

    always_comb begin
        {s_is_float, s_fpre, s_fl, s_sticky, s_cnt} = d_side;
        s_num   = BND_W'({s_cnt, {UW{1'b0}}});
        step_ok = (col_rem == '0) && (row_rem == '0);
        cnt_ok  = (s_cnt != '0) && (s_num >= r_lo_prod) && (s_num <= r_hi_prod);
        flt_ok  = s_fpre && (s_fl >= i_cfg.depth_lower)
                  && !((s_fl > i_cfg.depth_upper)
                       || ((s_fl == i_cfg.depth_upper) && s_sticky));
        ok      = step_ok && (s_is_float ? flt_ok : cnt_ok);
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            o_ok  <= ok;
            o_col <= d_col;
            o_row <= d_row;
            o_z   <= ok ? (s_is_float ? s_fl : cnt_quo) : '0;
        end
    end

endmodule

`default_nettype wire

// File: design/dpb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dpb_fifo #(
    parameter int W     = 48,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/dpb_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back end: pinhole projection X = (col - cx) * z / fx, Y likewise,
// truncated toward zero and saturated to 32 bits.
module dpb_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dpb_pkg::t_cfg             i_cfg,
    input  wire logic                      i_empty,
    output logic                           o_pop,
    input  wire logic                      i_ok,
    input  wire logic [COORD_BITS-1:0]     i_col,
    input  wire logic [COORD_BITS-1:0]     i_row,
    input  wire logic [dpb_pkg::Z_W-1:0]   i_z,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output logic                           o_point_valid,
    output logic [dpb_pkg::PT_W-1:0]       o_x,
    output logic [dpb_pkg::PT_W-1:0]       o_y,
    output logic [dpb_pkg::Z_W-1:0]        o_z
);

    localparam int ZW     = dpb_pkg::Z_W;
    localparam int FW     = dpb_pkg::FOCAL_W;
    localparam int QW     = dpb_pkg::PQUO_W;
    localparam int PW     = dpb_pkg::PT_W;
    localparam int SPAN_W = (COORD_BITS + 16 > FW) ? COORD_BITS + 16 : FW;
    localparam int DIFF_W = SPAN_W + 1;
    localparam int MAG_W  = DIFF_W + ZW + 1;
    localparam int HI_W   = MAG_W - QW;
    localparam int CMP_W  = (HI_W > FW) ? HI_W : FW;
    localparam int V      = 3 + QW + 1;
    localparam int XSIDE_W = 1 + ZW + 1 + 1;

    logic [V-1:0] r_vld;
    logic         b_en;

    assign b_en    = !r_vld[V-1] || i_ready;
    assign o_pop   = !i_empty && b_en;
    assign o_valid = r_vld[V-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (b_en) begin
            r_vld <= {r_vld[V-2:0], !i_empty};
        end
    end

    logic [FW-1:0] fx_eff, fy_eff;
    assign fx_eff = (i_cfg.focal_x == '0) ? FW'(1) : i_cfg.focal_x;
    assign fy_eff = (i_cfg.focal_y == '0) ? FW'(1) : i_cfg.focal_y;

    // offsets from the principal point
    logic              r1_ok;
    logic [ZW-1:0]     r1_z;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r1_ok <= i_ok;
            r1_z  <= i_z;
            r1_dx <= DIFF_W'({i_col, 16'h0000}) - DIFF_W'(i_cfg.center_x);
            r1_dy <= DIFF_W'({i_row, 16'h0000}) - DIFF_W'(i_cfg.center_y);
        end
    end

    // scale by depth
    logic              r2_ok;
    logic [ZW-1:0]     r2_z;
    logic signed [MAG_W-1:0] r2_px, r2_py;
    logic signed [MAG_W-1:0] zs;

    assign zs = MAG_W'($signed({1'b0, r1_z}));

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r2_ok <= r1_ok;
            r2_z  <= r1_z;
            r2_px <= MAG_W'(r1_dx) * zs;
            r2_py <= MAG_W'(r1_dy) * zs;
        end
    end

    // split into sign and magnitude
    logic             r3_ok, r3_sx, r3_sy;
    logic [ZW-1:0]    r3_z;
    logic [MAG_W-1:0] r3_mx, r3_my;

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r3_ok <= r2_ok;
            r3_z  <= r2_z;
            r3_sx <= r2_px[MAG_W-1];
            r3_sy <= r2_py[MAG_W-1];
            r3_mx <= r2_px[MAG_W-1] ? MAG_W'(-r2_px) : MAG_W'(r2_px);
            r3_my <= r2_py[MAG_W-1] ? MAG_W'(-r2_py) : MAG_W'(r2_py);
        end
    end

    logic ovf_x, ovf_y;
    assign ovf_x = CMP_W'(r3_mx[MAG_W-1:QW]) >= CMP_W'(fx_eff);
    assign ovf_y = CMP_W'(r3_my[MAG_W-1:QW]) >= CMP_W'(fy_eff);

    logic [QW-1:0]      qx, qy;
    logic [XSIDE_W-1:0] dx_side;
    logic [1:0]         dy_side;

    dpb_div #(.NUM_W(MAG_W), .DEN_W(FW), .QUO_W(QW), .SIDE_W(XSIDE_W)) u_x_div (
        .i_clk (i_clk), .i_en (b_en),
        .i_num (r3_mx), .i_den (fx_eff), .i_side ({r3_ok, r3_z, r3_sx, ovf_x}),
        .o_quo (qx), .o_rem (), .o_side (dx_side)
    );

    dpb_div #(.NUM_W(MAG_W), .DEN_W(FW), .QUO_W(QW), .SIDE_W(2)) u_y_div (
        .i_clk (i_clk), .i_en (b_en),
        .i_num (r3_my), .i_den (fy_eff), .i_side ({r3_sy, ovf_y}),
        .o_quo (qy), .o_rem (), .o_side (dy_side)
    );

    function automatic logic [PW-1:0] saturate(input logic neg, input logic ovf,
                                                input logic [QW-1:0] q);
        logic [PW-1:0] res;
        if (neg) begin
            if (ovf || (q > QW'(33'h080000000))) begin
                res = {1'b1, {(PW-1){1'b0}}};
            end else begin
                res = PW'(-q);
            end
        end else begin
            if (ovf || (q > QW'(33'h07FFFFFFF))) begin
                res = {1'b0, {(PW-1){1'b1}}};
            end else begin
                res = q[PW-1:0];
            end
        end
        return res;
    endfunction

    logic          s_ok, s_sx, s_ovx, s_sy, s_ovy;
    logic [ZW-1:0] s_z;

    always_comb begin
        {s_ok, s_z, s_sx, s_ovx} = dx_side;
        {s_sy, s_ovy}            = dy_side;
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            o_point_valid <= s_ok;
            o_x <= s_ok ? saturate(s_sx, s_ovx, qx) : '0;
            o_y <= s_ok ? saturate(s_sy, s_ovy, qy) : '0;
            o_z <= s_ok ? s_z : '0;
        end
    end

endmodule

`default_nettype wire

// File: design/dpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dpb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_s_axis_tready,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [87:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // reset empties the pipeline
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // reset leaves the input side open
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // a stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output changed");

    // dropped pixels carry an all-zero point
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 88'd0)
        else $error("dropped pixel with nonzero point");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (.*);

`default_nettype wire
